@@ hw/rtl/cartesian_to_spherical_macros.svh @@
// Assertion macros for the Cartesian to spherical converter.
`ifndef CARTESIAN_TO_SPHERICAL_MACROS_SVH
`define CARTESIAN_TO_SPHERICAL_MACROS_SVH
`ifndef SYNTHESIS
`define C2S_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("c2s: same-cycle check failed");
`define C2S_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("c2s: next-cycle check failed");
`else
`define C2S_ASSERT_IMP(lbl, ante, cons)
`define C2S_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ hw/rtl/c2s_pkg.sv @@
// Shared constants, types and functions for the Cartesian to spherical converter.
package c2s_pkg;

	localparam int COORD_W = 16;
	localparam int CORDIC_W = 32;
	localparam int ACC_W = 26;
	localparam int CORDIC_STEPS = 18;
	localparam int RAD_RW = 32;
	localparam int RAD_QW = (RAD_RW + 1) / 2;
	localparam int EL_RW = 57;
	localparam int EL_QW = (EL_RW + 1) / 2;
	localparam int ROUND_W = 18;

	localparam logic signed [ACC_W-1:0] HALF_TURN_ACC = ACC_W'(180 * 65536);
	localparam logic signed [ROUND_W-1:0] FULL_TURN = ROUND_W'(23040);
	localparam logic signed [ROUND_W-1:0] QUARTER_TURN = ROUND_W'(5760);
	localparam logic signed [COORD_W-1:0] ONE_Q14 = COORD_W'(16384);

	// pipeline depths, and the delay-line depths that align each unit's result
	localparam int CORDIC_LAT = CORDIC_STEPS + 1;
	localparam int EL_DONE = 2 + EL_QW + CORDIC_LAT;
	localparam int AZ_DELAY = EL_DONE - CORDIC_LAT;
	localparam int RAD_DELAY = EL_DONE - (2 + RAD_QW);
	localparam int ZED_DELAY = EL_QW;
	localparam int FLAG_DELAY = EL_DONE - 1;
	localparam int TOTAL_LAT = EL_DONE + 1;

	typedef struct packed {
		logic sat;
		logic neg;
		logic err;
	} el_flags_t;

	// atan(2^-i) in 2^-16 degree
	function automatic logic signed [ACC_W-1:0] atan_step(input logic [4:0] i);
		logic signed [ACC_W-1:0] v;
		case (i)
			5'd0: v = ACC_W'(2949120);
			5'd1: v = ACC_W'(1740967);
			5'd2: v = ACC_W'(919879);
			5'd3: v = ACC_W'(466945);
			5'd4: v = ACC_W'(234379);
			5'd5: v = ACC_W'(117304);
			5'd6: v = ACC_W'(58666);
			5'd7: v = ACC_W'(29335);
			5'd8: v = ACC_W'(14668);
			5'd9: v = ACC_W'(7334);
			5'd10: v = ACC_W'(3667);
			5'd11: v = ACC_W'(1833);
			5'd12: v = ACC_W'(917);
			5'd13: v = ACC_W'(458);
			5'd14: v = ACC_W'(229);
			5'd15: v = ACC_W'(115);
			5'd16: v = ACC_W'(57);
			5'd17: v = ACC_W'(29);
			default: v = '0;
		endcase
		return v;
	endfunction

	// round 2^-16 degree to 1/64 degree, half up
	function automatic logic signed [ROUND_W-1:0] round_64ths(
		input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W:0] t;
		t = {acc[ACC_W-1], acc} + (ACC_W+1)'(512);
		return ROUND_W'(t >>> 10);
	endfunction

endpackage

@@ hw/rtl/cartesian_to_spherical.sv @@
// Cartesian to spherical converter: radius, azimuth and elevation per vector.
// The pipeline depth from start to done is set by the elevation path
// (two setup stages, a 29-stage square root, then a 19-stage CORDIC).
// Throughput: one vector per cycle; busy is always low and done cannot stall.
// Reset clears only the valid pipeline; payload registers are not reset.
`include "cartesian_to_spherical_macros.svh"
module cartesian_to_spherical (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic signed [15:0] x_coord,
	input logic signed [15:0] y_coord,
	input logic signed [15:0] z_coord,
	output logic done,
	output logic [15:0] radius,
	output logic [14:0] azimuth,
	output logic signed [13:0] elevation,
	output logic domain_error
);

	localparam int LAT = c2s_pkg::TOTAL_LAT;
	localparam int CW = c2s_pkg::CORDIC_W;
	localparam int AW = c2s_pkg::ACC_W;
	localparam int RDW = c2s_pkg::ROUND_W;

	logic [LAT-1:0] vld_q;
	logic signed [31:0] xsq_c, ysq_c, zsq_c;
	logic [30:0] xsq_s1, ysq_s1, zsq_s1;
	logic signed [15:0] z_s1, z_s2;
	c2s_pkg::el_flags_t flags_s1, flags_d;
	logic [31:0] sum_s2;
	logic [c2s_pkg::EL_RW-1:0] el_rad_s2;
	logic [28:0] rest_c;
	logic [c2s_pkg::RAD_QW-1:0] rad_root, rad_d;
	logic [c2s_pkg::EL_QW-1:0] el_root;
	logic signed [15:0] z_d;
	logic signed [AW-1:0] az_angle, az_d, el_angle;
	logic signed [RDW-1:0] az_r, az_w1, az_w2, el_r, el_c;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start && !busy};
		end
	end

	assign xsq_c = x_coord * x_coord;
	assign ysq_c = y_coord * y_coord;
	assign zsq_c = z_coord * z_coord;

	always_ff @(posedge clk) begin
		xsq_s1 <= xsq_c[30:0];
		ysq_s1 <= ysq_c[30:0];
		zsq_s1 <= zsq_c[30:0];
		z_s1 <= z_coord;
		flags_s1.sat <= (z_coord >= c2s_pkg::ONE_Q14) || (z_coord <= -c2s_pkg::ONE_Q14);
		flags_s1.neg <= z_coord[15];
		flags_s1.err <= (z_coord > c2s_pkg::ONE_Q14) || (z_coord < -c2s_pkg::ONE_Q14);
	end

	// 1 - z^2 in Q28; meaningless when |z| >= 1, which bypasses this path
	assign rest_c = 29'(32'h1000_0000) - zsq_s1[28:0];

	always_ff @(posedge clk) begin
		sum_s2 <= {1'b0, xsq_s1} + {1'b0, ysq_s1} + {1'b0, zsq_s1};
		el_rad_s2 <= {rest_c, 28'b0};
		z_s2 <= z_s1;
	end

	c2s_isqrt #(.RW(c2s_pkg::RAD_RW), .QW(c2s_pkg::RAD_QW)) u_rad_sqrt (
		.clk(clk), .rad(sum_s2), .root(rad_root));

	c2s_delay #(.W(c2s_pkg::RAD_QW), .DEPTH(c2s_pkg::RAD_DELAY)) u_rad_dly (
		.clk(clk), .din(rad_root), .dout(rad_d));

	c2s_cordic #(.W(CW), .STEPS(c2s_pkg::CORDIC_STEPS)) u_az_cordic (
		.clk(clk),
		.x({{2{x_coord[15]}}, x_coord, 14'b0}),
		.y({{2{y_coord[15]}}, y_coord, 14'b0}),
		.angle(az_angle));

	c2s_delay #(.W(AW), .DEPTH(c2s_pkg::AZ_DELAY)) u_az_dly (
		.clk(clk), .din(az_angle), .dout(az_d));

	c2s_isqrt #(.RW(c2s_pkg::EL_RW), .QW(c2s_pkg::EL_QW)) u_el_sqrt (
		.clk(clk), .rad(el_rad_s2), .root(el_root));

	c2s_delay #(.W(16), .DEPTH(c2s_pkg::ZED_DELAY)) u_z_dly (
		.clk(clk), .din(z_s2), .dout(z_d));

	c2s_cordic #(.W(CW), .STEPS(c2s_pkg::CORDIC_STEPS)) u_el_cordic (
		.clk(clk),
		.x({{(CW - c2s_pkg::EL_QW){1'b0}}, el_root}),
		.y({{2{z_d[15]}}, z_d, 14'b0}),
		.angle(el_angle));

	c2s_delay #(.W($bits(c2s_pkg::el_flags_t)), .DEPTH(c2s_pkg::FLAG_DELAY)) u_flag_dly (
		.clk(clk), .din(flags_s1), .dout(flags_d));

	// wrap azimuth into one turn, clamp elevation to a quarter turn
	always_comb begin
		az_r = c2s_pkg::round_64ths(az_d);
		az_w1 = (az_r < 0) ? az_r + c2s_pkg::FULL_TURN : az_r;
		az_w2 = (az_w1 >= c2s_pkg::FULL_TURN) ? az_w1 - c2s_pkg::FULL_TURN : az_w1;
		el_r = c2s_pkg::round_64ths(el_angle);
		if (flags_d.sat) begin
			el_c = flags_d.neg ? -c2s_pkg::QUARTER_TURN : c2s_pkg::QUARTER_TURN;
		end else if (el_r > c2s_pkg::QUARTER_TURN) begin
			el_c = c2s_pkg::QUARTER_TURN;
		end else if (el_r < -c2s_pkg::QUARTER_TURN) begin
			el_c = -c2s_pkg::QUARTER_TURN;
		end else begin
			el_c = el_r;
		end
	end

	always_ff @(posedge clk) begin
		radius <= rad_d;
		azimuth <= az_w2[14:0];
		elevation <= el_c[13:0];
		domain_error <= flags_d.err;
	end

	assign done = vld_q[LAT-1];

	`C2S_ASSERT_IMP(a_err_sat, done && domain_error, elevation == 14'sd5760 || elevation == -14'sd5760)
	`C2S_ASSERT_IMP(a_az_range, done, azimuth < 15'd23040)
	`C2S_ASSERT_IMP(a_done_lat, done, $past(start, LAT))
	`C2S_ASSERT_NXT(a_enter, start && !busy, vld_q[0])

endmodule

@@ hw/rtl/c2s_delay.sv @@
// Fixed-depth register delay line for payload alignment.
module c2s_delay #(
	parameter int W = 1,
	parameter int DEPTH = 1
) (
	input logic clk,
	input logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] line_q [DEPTH];

	always_ff @(posedge clk) begin
		line_q[0] <= din;
		for (int k = 1; k < DEPTH; k++) begin
			line_q[k] <= line_q[k-1];
		end
	end

	assign dout = line_q[DEPTH-1];

endmodule

@@ hw/rtl/c2s_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
module c2s_isqrt #(
	parameter int RW = 32,
	parameter int QW = (RW + 1) / 2
) (
	input logic clk,
	input logic [RW-1:0] rad,
	output logic [QW-1:0] root
);

	localparam int TW = 2 * QW + 1;

	logic [RW-1:0] rem_s [QW];
	logic [QW-1:0] root_s [QW];

	for (genvar j = 0; j < QW; j++) begin : g_stage
		localparam int K = QW - 1 - j;
		logic [RW-1:0] rem_in;
		logic [QW-1:0] root_in;
		logic [TW-1:0] trial;
		logic [TW-1:0] rem_ext;

		if (j == 0) begin : g_first
			assign rem_in = rad;
			assign root_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[j-1];
			assign root_in = root_s[j-1];
		end

		// (root + 2^k)^2 - root^2
		assign trial = (TW'(root_in) << (K + 1)) + (TW'(1) << (2 * K));
		assign rem_ext = TW'(rem_in);

		always_ff @(posedge clk) begin
			if (rem_ext >= trial) begin
				rem_s[j] <= RW'(rem_ext - trial);
				root_s[j] <= root_in | (QW'(1) << K);
			end else begin
				rem_s[j] <= rem_in;
				root_s[j] <= root_in;
			end
		end
	end

	assign root = root_s[QW-1];

endmodule

@@ hw/rtl/c2s_cordic.sv @@
// Pipelined CORDIC vectoring unit: angle of (x, y) in 2^-16 degree.
module c2s_cordic #(
	parameter int W = c2s_pkg::CORDIC_W,
	parameter int STEPS = c2s_pkg::CORDIC_STEPS
) (
	input logic clk,
	input logic signed [W-1:0] x,
	input logic signed [W-1:0] y,
	output logic signed [c2s_pkg::ACC_W-1:0] angle
);

	logic signed [W-1:0] x_s [STEPS+1];
	logic signed [W-1:0] y_s [STEPS+1];
	logic signed [c2s_pkg::ACC_W-1:0] acc_s [STEPS+1];
	logic zero_s [STEPS+1];

	// fold the left half plane over before iterating
	always_ff @(posedge clk) begin
		zero_s[0] <= (x == '0) && (y == '0);
		if (x < 0) begin
			x_s[0] <= -x;
			y_s[0] <= -y;
			acc_s[0] <= (y < 0) ? -c2s_pkg::HALF_TURN_ACC : c2s_pkg::HALF_TURN_ACC;
		end else begin
			x_s[0] <= x;
			y_s[0] <= y;
			acc_s[0] <= '0;
		end
	end

	for (genvar j = 1; j <= STEPS; j++) begin : g_step
		always_ff @(posedge clk) begin
			zero_s[j] <= zero_s[j-1];
			if (y_s[j-1] > 0) begin
				x_s[j] <= x_s[j-1] + (y_s[j-1] >>> (j - 1));
				y_s[j] <= y_s[j-1] - (x_s[j-1] >>> (j - 1));
				acc_s[j] <= acc_s[j-1] + c2s_pkg::atan_step(5'(j - 1));
			end else begin
				x_s[j] <= x_s[j-1] - (y_s[j-1] >>> (j - 1));
				y_s[j] <= y_s[j-1] + (x_s[j-1] >>> (j - 1));
				acc_s[j] <= acc_s[j-1] - c2s_pkg::atan_step(5'(j - 1));
			end
		end
	end

	assign angle = zero_s[STEPS] ? '0 : acc_s[STEPS];

endmodule

@@ dv/cartesian_to_spherical_checker.sv @@
// Predicts and checks every converted vector leaving the Cartesian to spherical converter.
`timescale 1ns / 100ps
module cartesian_to_spherical_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic signed [15:0] x_coord,
	input logic signed [15:0] y_coord,
	input logic signed [15:0] z_coord,
	input logic done,
	input logic [15:0] radius,
	input logic [14:0] azimuth,
	input logic signed [13:0] elevation,
	input logic domain_error,
	output int fail_count,
	output int pending
);

	typedef struct packed {
		logic [15:0] radius;
		logic [14:0] azimuth;
		logic signed [13:0] elevation;
		logic domain_error;
	} sph_word_t;

	localparam longint FULL_64THS = 23040;
	localparam longint QUARTER_64THS = 5760;
	localparam longint ONE_RAW = 16384;

	sph_word_t sph_queue[$];

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return longint'(res);
	endfunction

	function automatic longint atan_deg16(int i);
		longint tab[18] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
			29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};
		return tab[i];
	endfunction

	// angle of (vx, vy) in 2^-16 degree, rounded to 1/64 degree
	function automatic longint angle_64ths(longint vx, longint vy);
		longint acc, nx, ny;
		acc = 0;
		if (vx == 0 && vy == 0) return 0;
		if (vx < 0) begin
			acc = (vy < 0) ? -180 * 65536 : 180 * 65536;
			vx = -vx;
			vy = -vy;
		end
		for (int i = 0; i < 18; i++) begin
			if (vy > 0) begin
				nx = vx + floor_shift(vy, i);
				ny = vy - floor_shift(vx, i);
				acc += atan_deg16(i);
			end else begin
				nx = vx - floor_shift(vy, i);
				ny = vy + floor_shift(vx, i);
				acc -= atan_deg16(i);
			end
			vx = nx;
			vy = ny;
		end
		return floor_shift(acc + 512, 10);
	endfunction

	function automatic sph_word_t convert_vector(longint x, longint y, longint z);
		sph_word_t w;
		longint r, az, el, c;
		r = int_sqrt(x * x + y * y + z * z);
		if (r > 65535) r = 65535;
		az = angle_64ths(x * 16384, y * 16384);
		if (az < 0) az += FULL_64THS;
		if (az >= FULL_64THS) az -= FULL_64THS;
		w.domain_error = 1'b0;
		if (z > ONE_RAW || z < -ONE_RAW) begin
			w.domain_error = 1'b1;
			el = (z > 0) ? QUARTER_64THS : -QUARTER_64THS;
		end else if (z == ONE_RAW || z == -ONE_RAW) begin
			el = (z > 0) ? QUARTER_64THS : -QUARTER_64THS;
		end else begin
			c = int_sqrt((ONE_RAW * ONE_RAW - z * z) << 28);
			el = angle_64ths(c, z * 16384);
			if (el > QUARTER_64THS) el = QUARTER_64THS;
			if (el < -QUARTER_64THS) el = -QUARTER_64THS;
		end
		w.radius = r[15:0];
		w.azimuth = az[14:0];
		w.elevation = el[13:0];
		return w;
	endfunction

	assign pending = sph_queue.size();

	always @(posedge clk or negedge arst_n) begin
		sph_word_t want;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (start && !busy)
				sph_queue.push_back(convert_vector(x_coord, y_coord, z_coord));
			if (done) begin
				if (sph_queue.size() == 0) begin
					$error("unexpected word: radius %0d azimuth %0d", radius, azimuth);
					fail_count <= fail_count + 1;
				end else begin
					want = sph_queue.pop_front();
					if (radius !== want.radius || azimuth !== want.azimuth ||
						elevation !== want.elevation || domain_error !== want.domain_error)
						fail_count <= fail_count + 1;
					if (radius !== want.radius)
						$error("radius: expected %0d, got %0d", want.radius, radius);
					if (azimuth !== want.azimuth)
						$error("azimuth: expected %0d, got %0d", want.azimuth, azimuth);
					if (elevation !== want.elevation)
						$error("elevation: expected %0d, got %0d", want.elevation, elevation);
					if (domain_error !== want.domain_error)
						$error("domain_error: expected %0d, got %0d", want.domain_error,
							domain_error);
				end
			end
		end
	end

endmodule

@@ dv/cartesian_to_spherical_test.sv @@
// Stimulus and verdict for the Cartesian to spherical converter.
`timescale 1ns / 100ps
module cartesian_to_spherical_test;

	localparam int RANDOM_WORDS = 1850;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 80;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [15:0] x_coord, y_coord, z_coord;
	logic done;
	logic [15:0] radius;
	logic [14:0] azimuth;
	logic signed [13:0] elevation;
	logic domain_error;
	int fail_count;
	int pending;
	int cycle_count = 0;
	int sent;

	cartesian_to_spherical i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.x_coord(x_coord), .y_coord(y_coord), .z_coord(z_coord),
		.done(done), .radius(radius), .azimuth(azimuth),
		.elevation(elevation), .domain_error(domain_error)
	);

	cartesian_to_spherical_checker i_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.x_coord(x_coord), .y_coord(y_coord), .z_coord(z_coord),
		.done(done), .radius(radius), .azimuth(azimuth),
		.elevation(elevation), .domain_error(domain_error),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("cartesian_to_spherical verification failed");
			$finish;
		end
	end

	// mostly values inside the unit range, with some full-range noise
	function automatic logic [15:0] pick_coord();
		case ($urandom_range(0, 9))
			0, 1: return 16'($urandom);
			2: return 16'($urandom_range(0, 8)) - 16'sd4;
			3: return ($urandom_range(0, 1)) ? 16'sd16384 : -16'sd16384;
			default: return 16'($urandom_range(0, 32768)) - 16'sd16384;
		endcase
	endfunction

	// hold start for one accepted word, optionally after an idle gap
	task automatic send_word(logic [15:0] x, logic [15:0] y, logic [15:0] z, bit idle_ok);
		while (idle_ok && $urandom_range(0, 99) < 36) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		x_coord <= x;
		y_coord <= y;
		z_coord <= z;
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
	endtask

	initial begin
		logic [15:0] edge_vals[8];
		edge_vals = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF, 16'h4000,
			16'hC000, 16'h4001};
		sent = 0;
		arst_n = 1'b0;
		start = 1'b0;
		x_coord = '0;
		y_coord = '0;
		z_coord = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// zero vector, axes, extremes, z at and just past one
		send_word(16'h0000, 16'h0000, 16'h0000, 1'b0);
		send_word(16'h8000, 16'h8000, 16'h8000, 1'b0);
		send_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
		send_word(16'hC000, 16'h0000, 16'hC001, 1'b0);
		send_word(16'hC000, 16'hFFFF, 16'h3FFF, 1'b0);
		for (int i = 0; i < 8; i++)
			send_word(edge_vals[i], edge_vals[(i + 3) % 8], edge_vals[(i + 5) % 8], 1'b1);
		for (int i = 0; i < 8; i++)
			send_word(edge_vals[7 - i], edge_vals[i], edge_vals[i], 1'b1);
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n == RANDOM_WORDS / 2) begin
				// drain fully once before resuming
				start <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			send_word(pick_coord(), pick_coord(), pick_coord(),
				!(n > 300 && n < 600));
		end
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("converted %0d vectors: axes, extremes, zero vector, z at and past one,",
			sent);
		$display("and random vectors with gaps and a back-to-back stretch");
		if (fail_count == 0 && pending == 0)
			$display("cartesian_to_spherical verification clean");
		else
			$display("cartesian_to_spherical verification failed");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/c2s_pkg.sv
hw/rtl/c2s_delay.sv
hw/rtl/c2s_isqrt.sv
hw/rtl/c2s_cordic.sv
hw/rtl/cartesian_to_spherical.sv
dv/cartesian_to_spherical_checker.sv
dv/cartesian_to_spherical_test.sv
